>>> rtl/core/bsff_pkg.sv
package bsff_pkg;

    // Operation codes carried on the op field of an input word.
    localparam logic [2:0] OP_LINE_WORD = 3'd0;
    localparam logic [2:0] OP_HOST_PUSH = 3'd1;
    localparam logic [2:0] OP_HOST_POP  = 3'd2;
    localparam logic [2:0] OP_TX_EMPTY  = 3'd3;
    localparam logic [2:0] OP_TX_DONE   = 3'd4;
    localparam logic [2:0] OP_TX_CLEAR  = 3'd5;

    // Fields of a received line word.
    localparam int          CALL_BIT       = 8;
    localparam logic [1:0]  CALL_INQUIRY   = 2'b10;
    localparam logic [4:0]  BROADCAST_SLOT = 5'd0;

    localparam int OP_W     = 3;
    localparam int WORD_W   = 9;
    localparam int BYTE_W   = 8;
    localparam int SLOT_W   = 5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
    } t_cmd;

endpackage

>>> rtl/core/bus_slot_filter_fifo_core.sv
// Slave interface of a 9-bit half-duplex slotted bus with a receive ring and a
// transmit queue. Each word on the start port is one event: a received line
// word, a host push or pop, a transmitter empty or complete event, or a clear
// of the transmit queue. A word is taken when start is high and busy is low;
// busy then stays high for one execute cycle, and the result is shown for
// exactly one cycle, marked by o_result_valid, in the cycle after that. The
// result cannot be held off, so the receiver must take it in that cycle. A
// new word may be offered in the very cycle the result is shown; a word is
// not accepted while the one before it is still executing. The execute
// cycle is needed because of the registered read port of the ring memories,
// which is read at the queue tail in the acceptance cycle and used in the
// execute cycle. The status flags (driver, receive data present,
// transmit room, transmit idle) follow the state at all times; the popped
// words and the nearly-full flag are only meaningful while o_result_valid is
// high. The slave address may be written through the configuration channel
// whenever busy is low.
module bus_slot_filter_fifo_core #(
    parameter int QUEUE_DEPTH     = 32,
    parameter int MESSAGE_RESERVE = 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Event channel.
    input  logic                          start,
    output logic                          busy,
    input  logic [bsff_pkg::OP_W-1:0]     i_op,
    input  logic [bsff_pkg::WORD_W-1:0]   i_line_word_in,
    input  logic                          i_frame_error,
    input  logic [bsff_pkg::BYTE_W-1:0]   i_host_byte,
    // Configuration channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bsff_pkg::SLOT_W-1:0]   i_cfg_data,
    // Result.
    output logic                          o_result_valid,
    output logic [bsff_pkg::WORD_W-1:0]   o_rx_word_out,
    output logic [bsff_pkg::BYTE_W-1:0]   o_line_byte_out,
    output logic                          o_line_byte_valid,
    output logic                          o_driver_on,
    output logic                          o_rx_available,
    output logic                          o_tx_room,
    output logic                          o_tx_nearly_full,
    output logic                          o_tx_idle
);

    bsff_pkg::t_cmd cmd;
    logic           ctrl_busy;

    bsff_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (ctrl_busy),
        .o_done  (o_result_valid),
        .o_cmd   (cmd)
    );

    bsff_dp #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .MESSAGE_RESERVE (MESSAGE_RESERVE)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_line_word_in    (i_line_word_in),
        .i_frame_error     (i_frame_error),
        .i_host_byte       (i_host_byte),
        .o_rx_word_out     (o_rx_word_out),
        .o_line_byte_out   (o_line_byte_out),
        .o_line_byte_valid (o_line_byte_valid),
        .o_driver_on       (o_driver_on),
        .o_rx_available    (o_rx_available),
        .o_tx_room         (o_tx_room),
        .o_tx_nearly_full  (o_tx_nearly_full),
        .o_tx_idle         (o_tx_idle)
    );

    assign busy        = ctrl_busy;
    assign o_cfg_ready = !ctrl_busy;

    // An accepted word always leads to the execute cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not enter execution");

    // A result strobe only follows an execute cycle.
    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without a preceding execute cycle");

    // The room and nearly-full thresholds exclude each other on one result.
    a_room_vs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_tx_room && o_tx_nearly_full))
        else $error("transmit room and nearly-full reported together");

    // A byte handed to the transmitter means the queue was not idle.
    a_send_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_line_byte_valid) |-> $past(!o_tx_idle))
        else $error("byte sent while the transmit side was idle");

endmodule

>>> rtl/core/bsff_ram.sv
module bsff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/bsff_ctrl.sv
module bsff_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    output logic            o_done,
    output bsff_pkg::t_cmd  o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;

    // A word is taken in the idle state and executed in the following cycle.
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy        = (r_state == ST_EXEC);
    assign o_done        = r_done;
    assign o_cmd.capture = (r_state == ST_IDLE) && i_start;
    assign o_cmd.exec    = (r_state == ST_EXEC);

endmodule

>>> rtl/core/bsff_dp.sv
module bsff_dp #(
    parameter int QUEUE_DEPTH     = 32,
    parameter int MESSAGE_RESERVE = 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bsff_pkg::t_cmd                i_cmd,
    input  logic                          i_cfg_we,
    input  logic [bsff_pkg::SLOT_W-1:0]   i_cfg_data,
    input  logic [bsff_pkg::OP_W-1:0]     i_op,
    input  logic [bsff_pkg::WORD_W-1:0]   i_line_word_in,
    input  logic                          i_frame_error,
    input  logic [bsff_pkg::BYTE_W-1:0]   i_host_byte,
    output logic [bsff_pkg::WORD_W-1:0]   o_rx_word_out,
    output logic [bsff_pkg::BYTE_W-1:0]   o_line_byte_out,
    output logic                          o_line_byte_valid,
    output logic                          o_driver_on,
    output logic                          o_rx_available,
    output logic                          o_tx_room,
    output logic                          o_tx_nearly_full,
    output logic                          o_tx_idle
);

    localparam int AW      = $clog2(QUEUE_DEPTH);
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int RoomThr = QUEUE_DEPTH - MESSAGE_RESERVE;
    localparam logic [AW-1:0] LastIdx  = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] MaxFill  = CW'(QUEUE_DEPTH - 1);

    // Captured input word.
    logic [bsff_pkg::OP_W-1:0]   r_op;
    logic [bsff_pkg::WORD_W-1:0] r_word;
    logic                        r_ferr;
    logic [bsff_pkg::BYTE_W-1:0] r_hbyte;

    // Queue and bus state.
    logic [AW-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [AW-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [CW-1:0] r_tx_count, n_tx_count;
    logic [bsff_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [bsff_pkg::SLOT_W-1:0] r_slave_address;
    logic r_send, n_send, r_driver, n_driver;

    // Result registers.
    logic [bsff_pkg::WORD_W-1:0] r_rx_out, n_rx_out;
    logic [bsff_pkg::BYTE_W-1:0] r_tx_out, n_tx_out;
    logic r_tx_valid, n_tx_valid, r_nearly, n_nearly;

    logic                        rx_we, tx_we;
    logic [bsff_pkg::WORD_W-1:0] rx_rdata;
    logic [bsff_pkg::BYTE_W-1:0] tx_rdata;
    logic [bsff_pkg::SLOT_W-1:0] call_slot;
    logic                        push_fill_high;

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
        next_idx = (idx == LastIdx) ? '0 : idx + 1'b1;
    endfunction

    // The read ports always follow the tails, so the word at the tail is ready
    // in the execute cycle.
    bsff_ram #(.WIDTH(bsff_pkg::WORD_W), .DEPTH(QUEUE_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_head),
        .i_wdata (r_word),
        .i_raddr (r_rx_tail),
        .o_rdata (rx_rdata)
    );

    bsff_ram #(.WIDTH(bsff_pkg::BYTE_W), .DEPTH(QUEUE_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_head),
        .i_wdata (r_hbyte),
        .i_raddr (r_tx_tail),
        .o_rdata (tx_rdata)
    );

    assign call_slot = r_word[bsff_pkg::SLOT_W-1:0];

    always_comb begin
        n_rx_head  = r_rx_head;
        n_rx_tail  = r_rx_tail;
        n_tx_head  = r_tx_head;
        n_tx_tail  = r_tx_tail;
        n_tx_count = r_tx_count;
        n_slot     = r_slot;
        n_send     = r_send;
        n_driver   = r_driver;
        n_rx_out   = '0;
        n_tx_out   = '0;
        n_tx_valid = 1'b0;
        n_nearly   = 1'b0;
        rx_we      = 1'b0;
        tx_we      = 1'b0;
        push_fill_high = 1'b0;
        if (i_cmd.exec) begin
            case (r_op)
                bsff_pkg::OP_LINE_WORD: begin
                    if (!r_ferr) begin
                        if (r_word[bsff_pkg::CALL_BIT]) begin
                            n_slot = call_slot;
                            if ((call_slot == r_slave_address) &&
                                (r_word[6:5] == bsff_pkg::CALL_INQUIRY) &&
                                (r_tx_count != '0)) begin
                                n_driver = 1'b1;
                                n_send   = 1'b1;
                            end
                        end
                        if ((n_slot == bsff_pkg::BROADCAST_SLOT) ||
                            (n_slot == r_slave_address)) begin
                            rx_we     = 1'b1;
                            n_rx_head = next_idx(r_rx_head);
                        end
                    end
                end
                bsff_pkg::OP_HOST_PUSH: begin
                    if (r_tx_count < MaxFill) begin
                        tx_we      = 1'b1;
                        n_tx_head  = next_idx(r_tx_head);
                        n_tx_count = r_tx_count + 1'b1;
                    end
                    if (RoomThr >= 0) begin
                        push_fill_high = (n_tx_count > CW'(RoomThr));
                    end
                    n_nearly = (RoomThr < 0) || push_fill_high;
                end
                bsff_pkg::OP_HOST_POP: begin
                    if (r_rx_head != r_rx_tail) begin
                        n_rx_out  = rx_rdata;
                        n_rx_tail = next_idx(r_rx_tail);
                    end
                end
                bsff_pkg::OP_TX_EMPTY: begin
                    if (r_send) begin
                        if (r_tx_count != '0) begin
                            n_tx_out   = tx_rdata;
                            n_tx_valid = 1'b1;
                            n_tx_tail  = next_idx(r_tx_tail);
                            n_tx_count = r_tx_count - 1'b1;
                        end else begin
                            n_send = 1'b0;
                        end
                    end
                end
                bsff_pkg::OP_TX_DONE: begin
                    n_driver = 1'b0;
                end
                bsff_pkg::OP_TX_CLEAR: begin
                    n_tx_head  = r_tx_tail;
                    n_tx_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_op;
            r_word  <= i_line_word_in;
            r_ferr  <= i_frame_error;
            r_hbyte <= i_host_byte;
        end
        if (i_cmd.exec) begin
            r_rx_out   <= n_rx_out;
            r_tx_out   <= n_tx_out;
            r_tx_valid <= n_tx_valid;
            r_nearly   <= n_nearly;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head       <= '0;
            r_rx_tail       <= '0;
            r_tx_head       <= '0;
            r_tx_tail       <= '0;
            r_tx_count      <= '0;
            r_slot          <= '0;
            r_send          <= 1'b0;
            r_driver        <= 1'b0;
            r_slave_address <= '0;
        end else begin
            r_rx_head  <= n_rx_head;
            r_rx_tail  <= n_rx_tail;
            r_tx_head  <= n_tx_head;
            r_tx_tail  <= n_tx_tail;
            r_tx_count <= n_tx_count;
            r_slot     <= n_slot;
            r_send     <= n_send;
            r_driver   <= n_driver;
            if (i_cfg_we) begin
                r_slave_address <= i_cfg_data;
            end
        end
    end

    // Status flags come straight from the state, which only moves at the end
    // of the execute cycle, so they show the state after the word.
    assign o_rx_word_out     = r_rx_out;
    assign o_line_byte_out   = r_tx_out;
    assign o_line_byte_valid = r_tx_valid;
    assign o_tx_nearly_full  = r_nearly;
    assign o_driver_on       = r_driver;
    assign o_rx_available    = (r_rx_head != r_rx_tail);
    assign o_tx_room         = (RoomThr > 0) && (r_tx_count < CW'(RoomThr));
    assign o_tx_idle         = (r_tx_count == '0) && !r_driver;

endmodule
